// ----- sv/glyph_glow_blur_3x3_assert.svh -----
// Assertion macros used by the checker of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef GLYPH_GLOW_BLUR_3X3_ASSERT_SVH
`define GLYPH_GLOW_BLUR_3X3_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GGB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ggb_pkg.sv -----
package ggb_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 64;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 5;
    localparam int ROW_W  = 6;
    localparam int TW_W   = 6;
    localparam int TH_W   = 7;
    localparam int SUM_W  = 18;
    localparam int ACC_W  = 27;
    localparam int X_W    = 32;
    localparam int Y_W    = 13;
    localparam int QUOT_W = 27;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_HEIGHT = 1'b1;

    localparam logic [TW_W-1:0] TILE_WIDTH_RESET  = 6'd8;
    localparam logic [TH_W-1:0] TILE_HEIGHT_RESET = 7'd16;

    // Gaussian weights in Q8: the centre weight 256 is a shift.
    localparam logic [PIX_W-1:0] W_SIDE = 8'd155;

    // Alpha scaling: round(V * 51 / (40 * 2^16)), done as (V*51 + half) >> 19, then / 5.
    localparam int ALPHA_MUL    = 51;
    localparam int ALPHA_HALF   = 1310720;
    localparam int ALPHA_SHIFT  = 19;
    localparam int ALPHA_SAT_IN = 1280;
    localparam int DIV5_MUL     = 52429;
    localparam int DIV5_SHIFT   = 18;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_PREV,
        ST_WR_END,
        ST_READ,
        ST_SUM,
        ST_SCALE,
        ST_LOAD
    } ggb_state_t;

    typedef struct packed {
        logic capture;
        logic wr_prev;
        logic wr_end;
        logic start_run0;
        logic start_run1;
        logic step;
        logic rd;
        logic sum;
        logic scale;
        logic load;
        logic last;
        logic done;
    } ggb_cmd_t;

    typedef struct packed {
        logic has_prev;
        logic row_end;
        logic tile_end;
        logic row_above;
        logic run_end;
        logic out_free;
    } ggb_status_t;

endpackage

// ----- sv/ggb_ctrl.sv -----
module ggb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  ggb_pkg::ggb_status_t st,
    output ggb_pkg::ggb_cmd_t    cmd
);
    import ggb_pkg::*;

    ggb_state_t state_reg;
    ggb_state_t state_next;
    logic       run1_reg;
    logic       run1_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            run1_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run1_reg  <= run1_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        run1_next   = run1_reg;
        cmd         = '0;
        pixel_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WR_PREV;
                end
            end
            ST_WR_PREV:
            begin
                cmd.wr_prev = st.has_prev;
                state_next  = ST_WR_END;
            end
            ST_WR_END:
            begin
                cmd.wr_end = st.row_end;
                // The row above is released first, then the last row at tile end.
                if (st.row_above && (st.has_prev || st.row_end))
                begin
                    cmd.start_run0 = 1'b1;
                    run1_next      = 1'b0;
                    state_next     = ST_READ;
                end
                else if (st.tile_end)
                begin
                    cmd.start_run1 = 1'b1;
                    run1_next      = 1'b1;
                    state_next     = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (st.out_free)
                begin
                    cmd.load = 1'b1;
                    if (st.run_end && !run1_reg && st.tile_end)
                    begin
                        cmd.start_run1 = 1'b1;
                        run1_next      = 1'b1;
                        state_next     = ST_READ;
                    end
                    else if (st.run_end)
                    begin
                        cmd.last   = 1'b1;
                        cmd.done   = run1_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/ggb_datapath.sv -----
module ggb_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ggb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ggb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [ggb_pkg::PIX_W-1:0]           pixel,
    input  logic                                result_ready,
    output logic                                result_valid,
    output logic [ggb_pkg::PIX_W-1:0]           luminance,
    output logic [ggb_pkg::PIX_W-1:0]           alpha,
    output logic [ggb_pkg::COL_W-1:0]           out_col,
    output logic [ggb_pkg::ROW_W-1:0]           out_row,
    output logic                                last_of_run,
    output logic                                tile_done,
    input  ggb_pkg::ggb_cmd_t                   cmd,
    output ggb_pkg::ggb_status_t                st
);
    import ggb_pkg::*;

    function automatic logic [1:0] mod3(input logic [ROW_W-1:0] v);
        logic [3:0] s;
        // 4 is 1 mod 3, so the base-4 digits sum to the same residue.
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]);
        if (s >= 4'd9)
        begin
            s = s - 4'd9;
        end
        if (s >= 4'd6)
        begin
            s = s - 4'd6;
        end
        if (s >= 4'd3)
        begin
            s = s - 4'd3;
        end
        return s[1:0];
    endfunction

    function automatic logic [SUM_W-1:0] hsum(
        input logic [PIX_W-1:0] centre,
        input logic [PIX_W-1:0] left,
        input logic             left_en,
        input logic [PIX_W-1:0] right,
        input logic             right_en
    );
        logic [SUM_W-1:0] s;
        s = {2'b00, centre, 8'h00};
        if (left_en)
        begin
            s = s + SUM_W'(left) * SUM_W'(W_SIDE);
        end
        if (right_en)
        begin
            s = s + SUM_W'(right) * SUM_W'(W_SIDE);
        end
        return s;
    endfunction

    function automatic logic [SUM_W-1:0] pick(
        input logic [1:0]       sel,
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b,
        input logic [SUM_W-1:0] c
    );
        logic [SUM_W-1:0] r;
        case (sel)
            2'd0:    r = a;
            2'd1:    r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    // Configuration.
    logic [TW_W-1:0] tile_width_reg;
    logic [TH_W-1:0] tile_height_reg;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg  <= TILE_WIDTH_RESET;
            tile_height_reg <= TILE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TILE_WIDTH:  tile_width_reg  <= cfg_data[TW_W-1:0];
                CFG_TILE_HEIGHT: tile_height_reg <= cfg_data[TH_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (tile_width_reg == '0)
        begin
            w_last = '0;
        end
        else if (tile_width_reg > TW_W'(MAX_WIDTH))
        begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = COL_W'(tile_width_reg - 1'b1);
        end
        if (tile_height_reg == '0)
        begin
            h_last = '0;
        end
        else if (tile_height_reg > TH_W'(MAX_HEIGHT))
        begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = ROW_W'(tile_height_reg - 1'b1);
        end
    end

    // Raster position and the two previous pixels of the row.
    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [PIX_W-1:0] rp0_reg;
    logic [PIX_W-1:0] rp1_reg;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic             row_end_cur;
    logic             tile_end_cur;

    // A position beyond a shrunk tile is clamped to the last column or row.
    assign c_cur        = (col_count_reg > w_last) ? w_last : col_count_reg;
    assign r_cur        = (row_count_reg > h_last) ? h_last : row_count_reg;
    assign row_end_cur  = (c_cur == w_last);
    assign tile_end_cur = row_end_cur && (r_cur == h_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            rp0_reg       <= '0;
            rp1_reg       <= '0;
        end
        else if (cmd.capture)
        begin
            if (tile_end_cur)
            begin
                col_count_reg <= '0;
                row_count_reg <= '0;
            end
            else if (row_end_cur)
            begin
                col_count_reg <= '0;
                row_count_reg <= r_cur + 1'b1;
            end
            else
            begin
                col_count_reg <= c_cur + 1'b1;
                row_count_reg <= r_cur;
            end
            if (row_end_cur)
            begin
                rp0_reg <= '0;
                rp1_reg <= '0;
            end
            else
            begin
                rp1_reg <= rp0_reg;
                rp0_reg <= pixel;
            end
        end
    end

    // Snapshot of the accepted pixel and its neighborhood.
    logic [PIX_W-1:0] p_reg;
    logic [PIX_W-1:0] prev0_reg;
    logic [PIX_W-1:0] prev1_reg;
    logic [COL_W-1:0] c_reg;
    logic [ROW_W-1:0] r_reg;
    logic             row_end_reg;
    logic             tile_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_end_reg  <= 1'b0;
            tile_end_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            row_end_reg  <= row_end_cur;
            tile_end_reg <= tile_end_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            p_reg     <= pixel;
            prev0_reg <= rp0_reg;
            prev1_reg <= rp1_reg;
            c_reg     <= c_cur;
            r_reg     <= r_cur;
        end
    end

    // Row stores: three banks of horizontal sums by row mod 3, raw bytes by row parity.
    logic [SUM_W-1:0] bank0_mem [MAX_WIDTH];
    logic [SUM_W-1:0] bank1_mem [MAX_WIDTH];
    logic [SUM_W-1:0] bank2_mem [MAX_WIDTH];
    logic [PIX_W-1:0] raw_mem   [2*MAX_WIDTH];

    logic [COL_W-1:0] wr_col;
    logic [SUM_W-1:0] wr_sum;
    logic [1:0]       wr_slot;
    logic             wr_en;

    assign wr_en   = cmd.wr_prev || cmd.wr_end;
    assign wr_col  = cmd.wr_prev ? (c_reg - 1'b1) : c_reg;
    assign wr_slot = mod3(r_reg);
    assign wr_sum  = cmd.wr_prev
                   ? hsum(prev0_reg, prev1_reg, (c_reg >= COL_W'(2)), p_reg, 1'b1)
                   : hsum(p_reg, prev0_reg, (c_reg != '0), '0, 1'b0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_slot)
                2'd0:    bank0_mem[wr_col] <= wr_sum;
                2'd1:    bank1_mem[wr_col] <= wr_sum;
                2'd2:    bank2_mem[wr_col] <= wr_sum;
                default: ;
            endcase
        end
        if (cmd.capture)
        begin
            raw_mem[{r_cur[0], c_cur}] <= pixel;
        end
    end

    // Result sequencing.
    logic [COL_W-1:0] res_col_reg;
    logic [COL_W-1:0] res_hi_reg;
    logic [ROW_W-1:0] res_q_reg;
    logic             res_up_reg;
    logic             res_below_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start_run0)
        begin
            res_col_reg   <= (c_reg != '0) ? (c_reg - 1'b1) : c_reg;
            res_hi_reg    <= row_end_reg ? c_reg : (c_reg - 1'b1);
            res_q_reg     <= r_reg - 1'b1;
            res_up_reg    <= (r_reg > ROW_W'(1));
            res_below_reg <= 1'b1;
        end
        else if (cmd.start_run1)
        begin
            res_col_reg   <= '0;
            res_hi_reg    <= c_reg;
            res_q_reg     <= r_reg;
            res_up_reg    <= (r_reg != '0);
            res_below_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            res_col_reg <= res_col_reg + 1'b1;
        end
    end

    logic [SUM_W-1:0] b0_q_reg;
    logic [SUM_W-1:0] b1_q_reg;
    logic [SUM_W-1:0] b2_q_reg;
    logic [PIX_W-1:0] raw_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            b0_q_reg  <= bank0_mem[res_col_reg];
            b1_q_reg  <= bank1_mem[res_col_reg];
            b2_q_reg  <= bank2_mem[res_col_reg];
            raw_q_reg <= raw_mem[{res_q_reg[0], res_col_reg}];
        end
    end

    // Vertical pass and alpha scaling.
    logic [1:0]       q_slot;
    logic [1:0]       up_slot;
    logic [1:0]       dn_slot;
    logic [SUM_W-1:0] centre_sum;
    logic [SUM_W-1:0] up_sum;
    logic [SUM_W-1:0] dn_sum;
    logic [ACC_W-1:0] v_next;
    logic [ACC_W-1:0] v_reg;
    logic [X_W-1:0]   x_val;
    logic [Y_W-1:0]   y_reg;
    logic [QUOT_W-1:0] quot;
    logic [PIX_W-1:0] alpha_next;

    assign q_slot     = mod3(res_q_reg);
    assign up_slot    = (q_slot == 2'd0) ? 2'd2 : (q_slot - 2'd1);
    assign dn_slot    = (q_slot == 2'd2) ? 2'd0 : (q_slot + 2'd1);
    assign centre_sum = pick(q_slot, b0_q_reg, b1_q_reg, b2_q_reg);
    assign up_sum     = pick(up_slot, b0_q_reg, b1_q_reg, b2_q_reg);
    assign dn_sum     = pick(dn_slot, b0_q_reg, b1_q_reg, b2_q_reg);

    always_comb
    begin
        v_next = ACC_W'({centre_sum, 8'h00});
        if (res_up_reg)
        begin
            v_next = v_next + ACC_W'(up_sum) * ACC_W'(W_SIDE);
        end
        if (res_below_reg)
        begin
            v_next = v_next + ACC_W'(dn_sum) * ACC_W'(W_SIDE);
        end
    end

    assign x_val = X_W'(v_reg) * X_W'(ALPHA_MUL) + X_W'(ALPHA_HALF);
    assign quot  = QUOT_W'(y_reg[10:0]) * QUOT_W'(DIV5_MUL);

    always_comb
    begin
        if ((raw_q_reg != '0) || (y_reg >= Y_W'(ALPHA_SAT_IN)))
        begin
            alpha_next = 8'hFF;
        end
        else
        begin
            alpha_next = quot[DIV5_SHIFT +: PIX_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            v_reg <= v_next;
        end
        if (cmd.scale)
        begin
            y_reg <= x_val[ALPHA_SHIFT +: Y_W];
        end
    end

    // Output register.
    logic             result_valid_reg;
    logic [PIX_W-1:0] lum_reg;
    logic [PIX_W-1:0] alpha_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             last_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lum_reg     <= raw_q_reg;
            alpha_reg   <= alpha_next;
            out_col_reg <= res_col_reg;
            out_row_reg <= res_q_reg;
            last_reg    <= cmd.last;
            done_reg    <= cmd.done;
        end
    end

    assign result_valid = result_valid_reg;
    assign luminance    = lum_reg;
    assign alpha        = alpha_reg;
    assign out_col      = out_col_reg;
    assign out_row      = out_row_reg;
    assign last_of_run  = last_reg;
    assign tile_done    = done_reg;

    assign st.has_prev  = (c_reg != '0);
    assign st.row_end   = row_end_reg;
    assign st.tile_end  = tile_end_reg;
    assign st.row_above = (r_reg != '0);
    assign st.run_end   = (res_col_reg == res_hi_reg);
    assign st.out_free  = !result_valid_reg || result_ready;

endmodule

// ----- sv/glyph_glow_blur_3x3.sv -----
// Glow mask of one glyph tile: pixels enter in raster order, and each result carries the raw
// byte as luminance and an alpha that is 255 for a set pixel, else 0.005 of the 3x3 Gaussian
// blur scaled to a byte and saturated. Results lag by one row; the last pixel of the tile also
// releases the whole last row. A pixel is taken in ST_IDLE and its two horizontal sums are
// then written in ST_WR_PREV and ST_WR_END, through the single write port of the row-sum
// banks. Every released result is then read, summed vertically, scaled and loaded in
// ST_READ, ST_SUM, ST_SCALE and ST_LOAD by one shared arithmetic path; ST_LOAD waits while
// the result side holds a stalled result. The next pixel is taken while the last result of
// a run still waits in the output register. Row stores hold garbage until written and need
// no clearing pass after reset; tile_width and tile_height may be written between pixels.
module glyph_glow_blur_3x3 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ggb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ggb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [ggb_pkg::PIX_W-1:0]        pixel,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [ggb_pkg::PIX_W-1:0]        luminance,
    output logic [ggb_pkg::PIX_W-1:0]        alpha,
    output logic [ggb_pkg::COL_W-1:0]        out_col,
    output logic [ggb_pkg::ROW_W-1:0]        out_row,
    output logic                             last_of_run,
    output logic                             tile_done
);
    import ggb_pkg::*;

    ggb_cmd_t    cmd;
    ggb_status_t st;

    ggb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .st          (st),
        .cmd         (cmd)
    );

    ggb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel        (pixel),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .luminance    (luminance),
        .alpha        (alpha),
        .out_col      (out_col),
        .out_row      (out_row),
        .last_of_run  (last_of_run),
        .tile_done    (tile_done),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

// ----- sv/ggb_checker.sv -----
`include "glyph_glow_blur_3x3_assert.svh"

module ggb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             pixel_valid,
    input logic                             pixel_ready,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [ggb_pkg::PIX_W-1:0]        luminance,
    input logic [ggb_pkg::PIX_W-1:0]        alpha,
    input logic [ggb_pkg::COL_W-1:0]        out_col,
    input logic [ggb_pkg::ROW_W-1:0]        out_row,
    input logic                             last_of_run,
    input logic                             tile_done
);
    import ggb_pkg::*;

    // A stalled result stays offered.
    `GGB_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result withdrawn before its transaction")

    // A stalled result keeps its payload.
    `GGB_ASSERT_NEXT(a_payload_held, result_valid && !result_ready, $stable(luminance) && $stable(alpha) && $stable(out_col) && $stable(out_row), "stalled result payload changed")

    // The end of a tile is always the end of the run of that pixel.
    `GGB_ASSERT_SAME(a_done_is_last, result_valid && tile_done, last_of_run, "tile_done without last_of_run")

    // A set pixel is fully opaque.
    `GGB_ASSERT_SAME(a_lit_opaque, result_valid && (luminance != 8'd0), alpha == 8'hFF, "nonzero pixel with alpha below 255")

    // After a pixel transaction the sums are written before another pixel is taken.
    `GGB_ASSERT_NEXT(a_pixel_gap, pixel_valid && pixel_ready, !pixel_ready, "pixel taken in back-to-back cycles")

endmodule

bind glyph_glow_blur_3x3 ggb_checker u_ggb_checker (.*);

// ----- tb/tb_glyph_glow_blur_3x3.sv -----
`timescale 1ns / 1ps

module tb_glyph_glow_blur_3x3;

    import ggb_pkg::*;

    localparam int unsigned TILE_MAX_W = 32;
    localparam int unsigned TILE_MAX_H = 64;
    localparam longint unsigned CENTER_WEIGHT = 256;
    localparam longint unsigned SIDE_WEIGHT = 155;
    localparam longint unsigned GLOW_NUM = 51;
    localparam longint unsigned GLOW_DEN = 2621440;
    localparam longint unsigned GLOW_ROUND = 1310720;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [PIX_W-1:0] luminance;
        logic [PIX_W-1:0] alpha;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last_of_run;
        logic             tile_done;
    } glow_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   pixel_valid;
    logic                   pixel_ready;
    logic [PIX_W-1:0]       pixel;
    logic                   result_valid;
    logic                   result_ready;
    logic [PIX_W-1:0]       luminance;
    logic [PIX_W-1:0]       alpha;
    logic [COL_W-1:0]       out_col;
    logic [ROW_W-1:0]       out_row;
    logic                   last_of_run;
    logic                   tile_done;

    // Shadow copy of the block's registers, stores and raster position.
    logic [TW_W-1:0]  width_reg = 6'd8;
    logic [TH_W-1:0]  height_reg = 7'd16;
    logic [17:0]      hsum_rows [3][TILE_MAX_W];
    logic [PIX_W-1:0] raw_rows [2][TILE_MAX_W];
    logic [PIX_W-1:0] prev_pix [2] = '{8'd0, 8'd0};
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;

    glow_result_t glow_expected [$];
    glow_result_t glow_want;
    int           glow_mismatches = 0;
    int           stall_cycles = 0;
    int           send_idle_pct = 0;
    int           ready_idle_pct = 0;

    glyph_glow_blur_3x3 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .luminance    (luminance),
        .alpha        (alpha),
        .out_col      (out_col),
        .out_row      (out_row),
        .last_of_run  (last_of_run),
        .tile_done    (tile_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    // Glow of the pixel at row q, column c; below tells whether row q+1 exists.
    function automatic glow_result_t glow_at(int unsigned q, int unsigned c, bit below);
        longint unsigned v;
        longint unsigned a;
        glow_result_t    res;
        v = 64'(hsum_rows[q % 3][c]);
        v = v * CENTER_WEIGHT;
        if (q >= 1)
            v += SIDE_WEIGHT * 64'(hsum_rows[(q - 1) % 3][c]);
        if (below)
            v += SIDE_WEIGHT * 64'(hsum_rows[(q + 1) % 3][c]);
        res.luminance = raw_rows[q % 2][c];
        if (res.luminance != 0)
        begin
            res.alpha = 8'd255;
        end
        else
        begin
            a = (v * GLOW_NUM + GLOW_ROUND) / GLOW_DEN;
            res.alpha = (a > 255) ? 8'd255 : a[7:0];
        end
        res.col = c[COL_W-1:0];
        res.row = q[ROW_W-1:0];
        res.last_of_run = 1'b0;
        res.tile_done = 1'b0;
        return res;
    endfunction

    function automatic void predict_glow(logic [PIX_W-1:0] p);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        int unsigned     r;
        longint unsigned s;
        int unsigned     slot;
        int unsigned     i;
        bit              row_end;
        bit              tile_end;
        glow_result_t    run [$];
        w = clamp_size(width_reg, TILE_MAX_W);
        h = clamp_size(height_reg, TILE_MAX_H);
        c = (col_pos < w) ? col_pos : w - 1;
        r = (row_pos < h) ? row_pos : h - 1;
        row_end = (c == w - 1);
        tile_end = row_end && (r == h - 1);
        slot = r % 3;
        raw_rows[r % 2][c] = p;
        // A pixel completes the horizontal sum of the column to its left.
        if (c >= 1)
        begin
            s = CENTER_WEIGHT * prev_pix[0] + SIDE_WEIGHT * p;
            if (c >= 2)
                s += SIDE_WEIGHT * prev_pix[1];
            hsum_rows[slot][c - 1] = s[17:0];
            if (r >= 1)
                run.push_back(glow_at(r - 1, c - 1, 1'b1));
        end
        if (row_end)
        begin
            s = CENTER_WEIGHT * p;
            if (c >= 1)
                s += SIDE_WEIGHT * prev_pix[0];
            hsum_rows[slot][c] = s[17:0];
            if (r >= 1)
                run.push_back(glow_at(r - 1, c, 1'b1));
            prev_pix[0] = 8'd0;
            prev_pix[1] = 8'd0;
        end
        else
        begin
            prev_pix[1] = prev_pix[0];
            prev_pix[0] = p;
        end
        if (tile_end)
        begin
            for (i = 0; i < w; i++)
                run.push_back(glow_at(r, i, 1'b0));
            col_pos = 0;
            row_pos = 0;
        end
        else if (row_end)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].last_of_run = 1'b1;
            run[run.size() - 1].tile_done = tile_end;
        end
        foreach (run[k])
            glow_expected.push_back(run[k]);
    endfunction

    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            glow_mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // Track configuration writes and pixel transactions, check each result transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TILE_WIDTH:  width_reg = cfg_data[TW_W-1:0];
                    CFG_TILE_HEIGHT: height_reg = cfg_data[TH_W-1:0];
                    default: ;
                endcase
            end
            if (pixel_valid && pixel_ready)
                predict_glow(pixel);
            if (result_valid && result_ready)
            begin
                if (glow_expected.size() == 0)
                begin
                    glow_mismatches++;
                    $display("%0t: unexpected result expected none actual col %0d row %0d",
                             $time, out_col, out_row);
                end
                else
                begin
                    glow_want = glow_expected.pop_front();
                    compare_field("luminance", glow_want.luminance, luminance);
                    compare_field("alpha", glow_want.alpha, alpha);
                    compare_field("out_col", glow_want.col, out_col);
                    compare_field("out_row", glow_want.row, out_row);
                    compare_field("last_of_run", glow_want.last_of_run, last_of_run);
                    compare_field("tile_done", glow_want.tile_done, tile_done);
                end
            end
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    always @(posedge clk)
        result_ready <= ($urandom_range(0, 99) >= ready_idle_pct);

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        ready_idle_pct = receiver_pct;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] value);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        pixel_valid <= 1'b1;
        pixel <= value;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    // Hold off the pixel stream until every pending result has come out,
    // then give the block time to finish the sum writes of the last pixel.
    task automatic wait_drained();
        pixel_valid <= 1'b0;
        do
            @(posedge clk);
        while (glow_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic set_tile(logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] ht);
        wait_drained();
        write_reg(CFG_TILE_WIDTH, wd);
        write_reg(CFG_TILE_HEIGHT, ht);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] random_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 8'd0;
        if (pick < 55)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_single_pixel_tiles();
        set_tile(7'd1, 7'd1);
        send_pixel(8'd0);
        send_pixel(8'd255);
    endtask

    task automatic test_zero_size_registers();
        set_tile(7'd0, 7'd0);
        send_pixel(8'hA5);
    endtask

    // A hole with set pixels above and beside it saturates alpha; the faint corner of 1 counts as set.
    task automatic test_small_tile();
        logic [PIX_W-1:0] pattern [9] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
                                          8'd255, 8'd0, 8'd0, 8'd1};
        set_tile(7'd3, 7'd3);
        foreach (pattern[k])
            send_pixel(pattern[k]);
    endtask

    // Shrinking both sizes in the middle of row 1 makes the next pixel end the tile.
    task automatic test_resize_mid_tile();
        logic [PIX_W-1:0] pattern [5] = '{8'd0, 8'd200, 8'd0, 8'd17, 8'd0};
        set_tile(7'd4, 7'd3);
        foreach (pattern[k])
            send_pixel(pattern[k]);
        set_tile(7'd2, 7'd1);
        send_pixel(8'd0);
    endtask

    task automatic test_random_tiles();
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] ht;
        int unsigned           tiles;
        int unsigned           count;
        for (int k = 0; k < 9; k++)
        begin
            if (k == 3)
                set_idling(53, 9);
            if (k == 6)
                set_idling(0, 0);
            tiles = 1;
            case (k)
                0: begin wd = 7'd5;  ht = 7'd2;   end
                1: begin wd = 7'd32; ht = 7'd2;   end
                2: begin wd = 7'd3;  ht = 7'd6;   end
                3: begin wd = 7'd1;  ht = 7'd64;  end
                // Bit 6 lies beyond the width register and must be dropped.
                4: begin wd = 7'h45; ht = 7'd0; tiles = 2; end
                5: begin wd = 7'd63; ht = 7'd1;   end
                6: begin wd = 7'd0;  ht = 7'd127; end
                7:
                begin
                    wd = 7'($urandom_range(1, 5));
                    ht = 7'($urandom_range(1, 5));
                end
                default: begin wd = 7'd2; ht = 7'd2; end
            endcase
            set_tile(wd, ht);
            count = tiles * clamp_size(wd[TW_W-1:0], TILE_MAX_W) * clamp_size(ht, TILE_MAX_H);
            repeat (count) send_pixel(random_pixel());
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_TILE_WIDTH;
        cfg_data <= '0;
        pixel_valid <= 1'b0;
        pixel <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(9, 53);
        test_single_pixel_tiles();
        test_zero_size_registers();
        test_small_tile();
        test_resize_mid_tile();
        test_random_tiles();

        wait_drained();
        if (glow_mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ggb_pkg.sv
sv/ggb_ctrl.sv
sv/ggb_datapath.sv
sv/glyph_glow_blur_3x3.sv
sv/ggb_checker.sv
tb/tb_glyph_glow_blur_3x3.sv
